// ===== hdl/scm_pkg.sv =====
// ============================================================================
// scm_pkg
// Shared constants, instruction codes, types and helpers for the stack
// calculator machine.
// ============================================================================
`default_nettype none

package scm_pkg;

    // Default number of stack entries.
    localparam int STACK_DEPTH_DEF = 1024;

    // Field widths.
    localparam int MODE_W = 4;
    localparam int VAL_W  = 31;
    localparam int WIDE_W = 62;

    // Instruction codes.
    localparam logic [MODE_W-1:0] MODE_START  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_NUM    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_POP    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_INV    = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DUP    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_SWP    = 4'd5;
    localparam logic [MODE_W-1:0] MODE_ADD    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SUB    = 4'd7;
    localparam logic [MODE_W-1:0] MODE_MUL    = 4'd8;
    localparam logic [MODE_W-1:0] MODE_DIV    = 4'd9;
    localparam logic [MODE_W-1:0] MODE_MOD    = 4'd10;
    localparam logic [MODE_W-1:0] MODE_FINISH = 4'd11;

    // Largest result magnitude that is allowed.
    localparam logic signed [WIDE_W-1:0] MAG_LIMIT = 62'sd1000000000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;
        logic load;
        logic exec;
        logic div_commit;
        logic swap2;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_finish;
        logic out_busy;
        logic need_div;
        logic need_swap2;
        logic div_done;
    } t_status;

    // True when a result lies outside the allowed magnitude.
    function automatic logic too_big(input logic signed [WIDE_W-1:0] r);
        return (r > MAG_LIMIT) || (r < -MAG_LIMIT);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/scm_if.sv =====
// ============================================================================
// scm_if
// Valid/ready channels for instruction words and result words.
// ============================================================================
`default_nettype none

interface scm_in_if import scm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, mode, value, input ready);
    modport sink   (input valid, mode, value, output ready);
endinterface

interface scm_out_if import scm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] result_value;
    logic                    error;

    modport source (output valid, result_value, error, input ready);
    modport sink   (input valid, result_value, error, output ready);
endinterface

`default_nettype wire

// ===== hdl/scm_ram.sv =====
// ============================================================================
// scm_ram
// Generic single-write, dual-read RAM with registered read data.
// ============================================================================
`default_nettype none

module scm_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

`default_nettype wire

// ===== hdl/scm_div.sv =====
// ============================================================================
// scm_div
// Iterative signed divider: one quotient bit per cycle, truncating quotient,
// remainder with the sign of the dividend.
// ============================================================================
`default_nettype none

module scm_div import scm_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic signed [VAL_W-1:0]   i_dividend,
    input  wire logic signed [VAL_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic signed [VAL_W:0]          o_quot,
    output logic signed [VAL_W:0]          o_rem
);

    localparam int CNT_W = $clog2(VAL_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [VAL_W-1:0] r_rem, n_rem;
    logic [VAL_W-1:0] r_quo, n_quo;
    logic [VAL_W-1:0] r_den, n_den;
    logic             r_qneg, n_qneg;
    logic             r_rneg, n_rneg;
    logic [VAL_W:0]   sh;
    logic [VAL_W+1:0] df;

    // One restoring step per cycle on magnitudes.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_qneg = r_qneg;
        n_rneg = r_rneg;
        sh     = {r_rem, r_quo[VAL_W-1]};
        df     = {1'b0, sh} - {2'b00, r_den};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(VAL_W - 1);
            n_rem  = '0;
            n_quo  = i_dividend[VAL_W-1] ? VAL_W'(-i_dividend) : VAL_W'(i_dividend);
            n_den  = i_divisor[VAL_W-1] ? VAL_W'(-i_divisor) : VAL_W'(i_divisor);
            n_qneg = i_dividend[VAL_W-1] ^ i_divisor[VAL_W-1];
            n_rneg = i_dividend[VAL_W-1];
        end else if (r_busy) begin
            if (!df[VAL_W+1]) begin
                n_rem = df[VAL_W-1:0];
                n_quo = {r_quo[VAL_W-2:0], 1'b1};
            end else begin
                n_rem = sh[VAL_W-1:0];
                n_quo = {r_quo[VAL_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_den  <= n_den;
        r_qneg <= n_qneg;
        r_rneg <= n_rneg;
    end

    // Signed results.
    assign o_done = r_done;
    assign o_quot = r_qneg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign o_rem  = r_rneg ? -$signed({1'b0, r_rem}) : $signed({1'b0, r_rem});

`ifndef NO_ASSERTIONS
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == '0) |=> (o_done && !r_busy))
        else $error("divider did not finish after its last step");
`endif

endmodule

`default_nettype wire

// ===== hdl/scm_datapath.sv =====
// ============================================================================
// scm_datapath
// Stack memory, depth and error registers, arithmetic unit, divider and
// result word register.
// ============================================================================
`default_nettype none

module scm_datapath import scm_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cmd                    i_cmd,
    output t_status                      o_status,
    input  wire logic [MODE_W-1:0]       i_mode,
    input  wire logic signed [VAL_W-1:0] i_value,
    output logic                         o_res_valid,
    input  wire logic                    i_res_ready,
    output logic signed [VAL_W-1:0]      o_result_value,
    output logic                         o_error
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [MODE_W-1:0]       r_mode, n_mode;
    logic signed [VAL_W-1:0] r_value, n_value;
    logic signed [VAL_W-1:0] r_a, n_a;
    logic [DW-1:0]           r_depth, n_depth;
    logic                    r_err, n_err;
    logic                    r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0] r_out_value, n_out_value;
    logic                    r_out_error, n_out_error;

    logic [DW-1:0]           depth_m1, depth_m2;
    logic [AW-1:0]           raddr0, waddr;
    logic                    we;
    logic signed [VAL_W-1:0] wdata;
    logic [VAL_W-1:0]        rd0_raw, rd1_raw;
    logic signed [VAL_W-1:0] a, b;
    logic signed [WIDE_W-1:0] a_x, b_x, sum_x, diff_x, prod_x, neg_x, div_x;
    logic                    full, has1, has2;
    logic                    div_start, div_done;
    logic signed [VAL_W:0]   div_q, div_r, div_sel;

    assign depth_m1 = r_depth - DW'(1);
    assign depth_m2 = r_depth - DW'(2);
    assign raddr0   = (r_mode == MODE_FINISH) ? '0 : depth_m1[AW-1:0];
    assign full     = (r_depth == DW'(STACK_DEPTH));
    assign has1     = (r_depth != '0);
    assign has2     = (r_depth >= DW'(2));

    scm_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (depth_m2[AW-1:0]),
        .o_rdata0 (rd0_raw),
        .o_rdata1 (rd1_raw)
    );

    // Top of stack and the entry below it.
    assign a      = $signed(rd0_raw);
    assign b      = $signed(rd1_raw);
    assign a_x    = WIDE_W'(a);
    assign b_x    = WIDE_W'(b);
    assign sum_x  = b_x + a_x;
    assign diff_x = b_x - a_x;
    assign prod_x = b * a;
    assign neg_x  = -a_x;

    assign div_start = i_cmd.exec && o_status.need_div;

    scm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (b),
        .i_divisor  (a),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    assign div_sel = (r_mode == MODE_DIV) ? div_q : div_r;
    assign div_x   = WIDE_W'(div_sel);

    // Status toward the controller.
    always_comb begin
        o_status.is_finish  = (r_mode == MODE_FINISH);
        o_status.out_busy   = r_out_valid;
        o_status.need_div   = ((r_mode == MODE_DIV) || (r_mode == MODE_MOD)) && !r_err
                              && has2 && (a != '0);
        o_status.need_swap2 = (r_mode == MODE_SWP) && !r_err && has2;
        o_status.div_done   = div_done;
    end

    // Execution of one instruction word.
    always_comb begin
        n_mode      = r_mode;
        n_value     = r_value;
        n_a         = r_a;
        n_depth     = r_depth;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out_value = r_out_value;
        n_out_error = r_out_error;
        we          = 1'b0;
        waddr       = r_depth[AW-1:0];
        wdata       = r_value;

        if (i_cmd.load) begin
            n_mode  = i_mode;
            n_value = i_value;
        end

        if (i_cmd.exec) begin
            case (r_mode)
                MODE_START: begin
                    n_depth = DW'(1);
                    n_err   = 1'b0;
                    we      = 1'b1;
                    waddr   = '0;
                end
                MODE_FINISH: begin
                    n_out_valid = 1'b1;
                    n_out_error = r_err || (r_depth != DW'(1));
                    n_out_value = n_out_error ? '0 : a;
                end
                default: begin
                    if (!r_err) begin
                        case (r_mode)
                            MODE_NUM: begin
                                if (full) begin
                                    n_err = 1'b1;
                                end else begin
                                    we      = 1'b1;
                                    n_depth = r_depth + DW'(1);
                                end
                            end
                            MODE_POP: begin
                                if (!has1) n_err = 1'b1;
                                else n_depth = depth_m1;
                            end
                            MODE_INV: begin
                                if (!has1 || too_big(neg_x)) begin
                                    n_err = 1'b1;
                                end else begin
                                    we    = 1'b1;
                                    waddr = depth_m1[AW-1:0];
                                    wdata = neg_x[VAL_W-1:0];
                                end
                            end
                            MODE_DUP: begin
                                if (!has1 || full) begin
                                    n_err = 1'b1;
                                end else begin
                                    we      = 1'b1;
                                    wdata   = a;
                                    n_depth = r_depth + DW'(1);
                                end
                            end
                            MODE_SWP: begin
                                if (!has2) begin
                                    n_err = 1'b1;
                                end else begin
                                    we    = 1'b1;
                                    waddr = depth_m1[AW-1:0];
                                    wdata = b;
                                    n_a   = a;
                                end
                            end
                            MODE_ADD, MODE_SUB, MODE_MUL: begin
                                if (!has2) begin
                                    n_err = 1'b1;
                                end else begin
                                    case (r_mode)
                                        MODE_ADD: wdata = sum_x[VAL_W-1:0];
                                        MODE_SUB: wdata = diff_x[VAL_W-1:0];
                                        default:  wdata = prod_x[VAL_W-1:0];
                                    endcase
                                    if ((r_mode == MODE_ADD && too_big(sum_x))
                                        || (r_mode == MODE_SUB && too_big(diff_x))
                                        || (r_mode == MODE_MUL && too_big(prod_x))) begin
                                        n_err = 1'b1;
                                    end else begin
                                        we      = 1'b1;
                                        waddr   = depth_m2[AW-1:0];
                                        n_depth = depth_m1;
                                    end
                                end
                            end
                            MODE_DIV, MODE_MOD: begin
                                // Underflow or a zero divisor; otherwise the divider runs.
                                if (!has2 || a == '0) n_err = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            endcase
        end

        // Second half of a swap.
        if (i_cmd.swap2) begin
            we    = 1'b1;
            waddr = depth_m2[AW-1:0];
            wdata = r_a;
        end

        // Divider result is written back.
        if (i_cmd.div_commit) begin
            if (too_big(div_x)) begin
                n_err = 1'b1;
            end else begin
                we      = 1'b1;
                waddr   = depth_m2[AW-1:0];
                wdata   = div_x[VAL_W-1:0];
                n_depth = depth_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_depth     <= n_depth;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_mode      <= n_mode;
        r_value     <= n_value;
        r_a         <= n_a;
        r_out_value <= n_out_value;
        r_out_error <= n_out_error;
    end

    assign o_res_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_error        = r_out_error;

`ifndef NO_ASSERTIONS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");
    a_finish_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && o_status.is_finish) |=> r_out_valid)
        else $error("finish did not produce a result word");
`endif

endmodule

`default_nettype wire

// ===== hdl/scm_ctrl.sv =====
// ============================================================================
// scm_ctrl
// Sequencer: accept a word, read the stack, execute, then wait on the
// divider or finish a swap.
// ============================================================================
`default_nettype none

module scm_ctrl import scm_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EX   = 3'd2;
    localparam logic [2:0] ST_DIVW = 3'd3;
    localparam logic [2:0] ST_SWP2 = 3'd4;

    logic [2:0] r_state, n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_EX;
            end
            ST_EX: begin
                if (!(i_status.is_finish && i_status.out_busy)) begin
                    o_cmd.exec = 1'b1;
                    if (i_status.need_div) n_state = ST_DIVW;
                    else if (i_status.need_swap2) n_state = ST_SWP2;
                    else n_state = ST_IDLE;
                end
            end
            ST_DIVW: begin
                if (i_status.div_done) begin
                    o_cmd.div_commit = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_SWP2: begin
                o_cmd.swap2 = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_RD))
        else $error("accepted word did not go to the read step");
    a_div_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_commit |=> (r_state == ST_IDLE))
        else $error("divide commit did not return to idle");
`endif

endmodule

`default_nettype wire

// ===== hdl/stack_calculator_machine.sv =====
// Each word passes accept, stack read and execute; SWP adds a step for the
// second half of the swap, and DIV and MOD wait on the 31-step divider.
// A FINISH result word is registered at the end of the execute step, which is
// held while the previous result word still waits on the output channel.
// The sequencer accepts a new word only once the previous one is finished.
// Reset clears the depth, the error flag, the sequencer and the result valid;
// the stack memory is not cleared.
// ============================================================================
// stack_calculator_machine
// Reverse-Polish stack calculator executing one instruction word at a time.
// ============================================================================
`default_nettype none

module stack_calculator_machine import scm_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    scm_in_if.sink    i_item,
    scm_out_if.source o_res
);

    t_cmd    cmd;
    t_status status;

    scm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_item.valid),
        .i_status (status),
        .o_cmd    (cmd)
    );

    scm_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_mode         (i_item.mode),
        .i_value        (i_item.value),
        .o_res_valid    (o_res.valid),
        .i_res_ready    (o_res.ready),
        .o_result_value (o_res.result_value),
        .o_error        (o_res.error)
    );

    assign i_item.ready = cmd.ready;

endmodule

`default_nettype wire
